FILE: hdl/bqeq_pkg.sv
// Shared constants, codes and the sequencer's control store for the biquad cascade equalizer.
// No dependencies; used by the top level and by the port checker.
package bqeq_pkg;

   // Sizing
   localparam int BANDS        = 5;
   localparam int MAX_CHANNELS = 2;
   localparam int NCOEF        = BANDS * 5;
   localparam int HIST_DEPTH   = MAX_CHANNELS * BANDS * 4;
   localparam int HA_W         = $clog2(HIST_DEPTH);
   localparam int CA_W         = $clog2(NCOEF);
   localparam int BAND_W       = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W        = (CH_W + 1 > 2) ? CH_W + 1 : 2;

   // Fixed point
   localparam int          QSHIFT = 30;
   localparam logic [31:0] Q_ONE  = 32'h4000_0000;

   // Stream layout
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 3;

   // Item kinds (req_tuser[1:0])
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_COEF   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_ACTIVE    = 2'd0;
   localparam logic [1:0] CSR_PRE_SCALE = 2'd1;
   localparam logic [1:0] CSR_CHANNELS  = 2'd2;

   // History slots within a band
   localparam logic [1:0] SLOT_X1 = 2'd0;
   localparam logic [1:0] SLOT_X2 = 2'd1;
   localparam logic [1:0] SLOT_Y1 = 2'd2;
   localparam logic [1:0] SLOT_Y2 = 2'd3;

   // Coefficient positions within a band
   localparam logic [2:0] K_B0 = 3'd0;
   localparam logic [2:0] K_B1 = 3'd1;
   localparam logic [2:0] K_B2 = 3'd2;
   localparam logic [2:0] K_A1 = 3'd3;
   localparam logic [2:0] K_A2 = 3'd4;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic {MA_PRE, MA_COEF} mul_a_type;
   typedef enum logic {MB_X, MB_RD} mul_b_type;
   typedef enum logic [1:0] {WR_NONE, WR_RD, WR_X, WR_Y} wr_sel_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_WAIT} seq_type;

   typedef enum logic [3:0] {
      UP_IDLE,
      UP_PRE_MUL,
      UP_PRE_ACC,
      UP_PRE_Y,
      UP_BAND_0,
      UP_BAND_1,
      UP_BAND_2,
      UP_BAND_3,
      UP_BAND_4,
      UP_BAND_5,
      UP_BAND_6,
      UP_DONE
   } upc_type;

   typedef struct packed {
      acc_op_type acc_op;
      mul_a_type  mul_a;
      logic [2:0] coef_k;
      mul_b_type  mul_b;
      logic [1:0] rd_slot;
      wr_sel_type wr_sel;
      logic [1:0] wr_slot;
      logic       x_from_y;
      logic       band_clr;
      seq_type    seq;
      upc_type    target;
   } ucode_type;

   localparam ucode_type UC_NOP = '{
      acc_op: ACC_HOLD, mul_a: MA_COEF, coef_k: K_B0, mul_b: MB_X,
      rd_slot: SLOT_X1, wr_sel: WR_NONE, wr_slot: SLOT_X1, x_from_y: 1'b0,
      band_clr: 1'b0, seq: SEQ_NEXT, target: UP_IDLE};

   // Control store. The multiplier result is registered, so each step that
   // accumulates takes the product formed in the step before it.
   function automatic ucode_type ucode_rom(input upc_type pc);
      ucode_type w;
      w = UC_NOP;
      case (pc)
         UP_PRE_MUL: begin
            w.mul_a = MA_PRE;
            w.mul_b = MB_X;
         end
         UP_PRE_ACC: begin
            w.acc_op = ACC_LOAD;
         end
         UP_PRE_Y: begin
            w.x_from_y = 1'b1;
            w.band_clr = 1'b1;
         end
         UP_BAND_0: begin
            w.rd_slot = SLOT_X1;
            w.coef_k  = K_B0;
            w.mul_b   = MB_X;
         end
         UP_BAND_1: begin
            w.rd_slot = SLOT_X2;
            w.coef_k  = K_B1;
            w.mul_b   = MB_RD;
            w.acc_op  = ACC_LOAD;
            w.wr_sel  = WR_RD;
            w.wr_slot = SLOT_X2;
         end
         UP_BAND_2: begin
            w.rd_slot = SLOT_Y1;
            w.coef_k  = K_B2;
            w.mul_b   = MB_RD;
            w.acc_op  = ACC_ADD;
            w.wr_sel  = WR_X;
            w.wr_slot = SLOT_X1;
         end
         UP_BAND_3: begin
            w.rd_slot = SLOT_Y2;
            w.coef_k  = K_A1;
            w.mul_b   = MB_RD;
            w.acc_op  = ACC_ADD;
            w.wr_sel  = WR_RD;
            w.wr_slot = SLOT_Y2;
         end
         UP_BAND_4: begin
            w.coef_k = K_A2;
            w.mul_b  = MB_RD;
            w.acc_op = ACC_SUB;
         end
         UP_BAND_5: begin
            w.acc_op = ACC_SUB;
         end
         UP_BAND_6: begin
            w.x_from_y = 1'b1;
            w.wr_sel   = WR_Y;
            w.wr_slot  = SLOT_Y1;
            w.seq      = SEQ_LOOP;
            w.target   = UP_BAND_0;
         end
         UP_DONE: begin
            w.seq = SEQ_WAIT;
         end
         default: begin
            w = UC_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/biquad_cascade_equalizer_unit.sv
// Cascaded Direct Form I biquad equalizer: microcoded sequencer over one shared multiply-accumulate.
// Depends on bqeq_pkg (sizing, codes, control store).
//
// Usage:
//  - req_* carries items: audio samples, coefficient loads and history clears
//    (kind in req_tuser). Only samples produce a transfer on rsp_*.
//  - csr_* writes active, pre_scale and channels; write only while idle.
//  - Filtered sample: one 32x32 multiplier, registered, feeding a 64-bit
//    accumulator. The sequencer runs 3 pre-scale steps, 7 steps per band and
//    one output step; that step loads the result register, and rsp_tvalid
//    rises in the same cycle that req_tready returns for the next item.
//  - Bypassed sample: goes straight to the output step and is sent unchanged.
//  - Coefficient load and clear complete in the transfer cycle; the block stays idle.
//  - History sits in a single-port-write RAM with per-entry valid flops;
//    an entry whose flag is clear reads as zero, so clears are immediate.
//  - Reset: coefficients zero, history invalid, channel position 0,
//    active 0, pre_scale 1.0, channels 2. No clearing pass is needed.
//  - A stalled rsp holds its data; the sequencer waits in its output step
//    and req_tready stays low until the result register frees up.
module biquad_cascade_equalizer_unit (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // sample_in[31:0], coef_index[36:32], coef_value[68:37]
   input  logic [2:0]  req_tuser,   // mode[1:0], start_of_buffer[2]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample_out[31:0]
   output logic        rsp_tuser,   // channel[0]
   // register writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Field unpacking
   logic [1:0]  req_mode;
   logic        req_sob;
   logic [31:0] req_sample;
   logic [4:0]  req_coef_index;
   logic [31:0] req_coef_value;

   assign req_mode       = req_tuser[1:0];
   assign req_sob        = req_tuser[2];
   assign req_sample     = req_tdata[31:0];
   assign req_coef_index = req_tdata[36:32];
   assign req_coef_value = req_tdata[68:37];

   // Configuration
   logic        active_ff, active_in;
   logic [31:0] pre_scale_ff, pre_scale_in;
   logic [1:0]  channels_ff, channels_in;

   // Control state
   bqeq_pkg::upc_type           upc_ff, upc_in;
   logic [bqeq_pkg::BAND_W-1:0] band_ff, band_in;
   logic [bqeq_pkg::CH_W-1:0]   pos_ff, pos_in;
   logic [bqeq_pkg::CH_W-1:0]   ch_ff, ch_in;
   logic [bqeq_pkg::HIST_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0] coef_ff [bqeq_pkg::NCOEF];
   logic [31:0] coef_in [bqeq_pkg::NCOEF];
   logic        rsp_tvalid_ff, rsp_tvalid_in;

   // Datapath
   logic [31:0]        x_ff, x_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tuser_ff, rsp_tuser_in;
   logic               rsp_load;

   // History RAM
   logic [31:0]                 hist_mem [bqeq_pkg::HIST_DEPTH];
   logic [31:0]                 rd_data_ff;
   logic                        rd_vld_ff;
   logic [bqeq_pkg::HA_W-1:0]   rd_addr, wr_addr;
   logic                        wr_en;
   logic [31:0]                 wr_data;

   bqeq_pkg::ucode_type         uc;
   logic                        accept;
   logic                        out_free;
   logic [31:0]                 rd_val;
   logic [31:0]                 y_val;
   logic [31:0]                 coef_rd;
   logic [bqeq_pkg::CA_W-1:0]   coef_addr;
   logic signed [31:0]          mul_a_val, mul_b_val;
   logic [bqeq_pkg::CMP_W-1:0]  nch, pos_cur, pos_nxt, ch_cfg;
   logic                        band_last;

   assign uc         = bqeq_pkg::ucode_rom(upc_ff);
   assign req_tready = (upc_ff == bqeq_pkg::UP_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign band_last  = (band_ff == bqeq_pkg::BAND_W'(bqeq_pkg::BANDS - 1));

   // Operand selection
   assign rd_val    = rd_vld_ff ? rd_data_ff : 32'd0;
   assign y_val     = acc_ff[bqeq_pkg::QSHIFT+31:bqeq_pkg::QSHIFT];
   assign coef_addr = bqeq_pkg::CA_W'(int'(band_ff) * 5 + int'(uc.coef_k));
   assign coef_rd   = coef_ff[coef_addr];
   assign mul_a_val = (uc.mul_a == bqeq_pkg::MA_PRE) ? pre_scale_ff : coef_rd;
   assign mul_b_val = (uc.mul_b == bqeq_pkg::MB_X) ? x_ff : rd_val;
   assign prod_in   = mul_a_val * mul_b_val;

   // History addressing: row is channel*BANDS + band, four slots per row
   assign rd_addr = bqeq_pkg::HA_W'((int'(ch_ff) * bqeq_pkg::BANDS + int'(band_ff)) * 4
                                    + int'(uc.rd_slot));
   assign wr_addr = bqeq_pkg::HA_W'((int'(ch_ff) * bqeq_pkg::BANDS + int'(band_ff)) * 4
                                    + int'(uc.wr_slot));
   assign wr_en   = (uc.wr_sel != bqeq_pkg::WR_NONE);

   always_comb begin
      case (uc.wr_sel)
         bqeq_pkg::WR_RD: wr_data = rd_val;
         bqeq_pkg::WR_X:  wr_data = x_ff;
         bqeq_pkg::WR_Y:  wr_data = y_val;
         default:         wr_data = 32'd0;
      endcase
   end

   // Accumulator
   always_comb begin
      case (uc.acc_op)
         bqeq_pkg::ACC_LOAD: acc_in = prod_ff;
         bqeq_pkg::ACC_ADD:  acc_in = acc_ff + prod_ff;
         bqeq_pkg::ACC_SUB:  acc_in = acc_ff - prod_ff;
         default:            acc_in = acc_ff;
      endcase
   end

   // Channel position for an incoming sample
   always_comb begin
      ch_cfg = bqeq_pkg::CMP_W'(channels_ff);
      if (ch_cfg == '0) begin
         nch = bqeq_pkg::CMP_W'(1);
      end else if (ch_cfg > bqeq_pkg::CMP_W'(bqeq_pkg::MAX_CHANNELS)) begin
         nch = bqeq_pkg::CMP_W'(bqeq_pkg::MAX_CHANNELS);
      end else begin
         nch = ch_cfg;
      end
      pos_cur = req_sob ? '0 : bqeq_pkg::CMP_W'(pos_ff);
      if (pos_cur >= nch) begin
         pos_cur = '0;
      end
      pos_nxt = pos_cur + bqeq_pkg::CMP_W'(1);
      if (pos_nxt >= nch) begin
         pos_nxt = '0;
      end
   end

   // Next-state logic: accept dispatch, sequencer, stores
   always_comb begin
      active_in     = active_ff;
      pre_scale_in  = pre_scale_ff;
      channels_in   = channels_ff;
      upc_in        = upc_ff;
      band_in       = band_ff;
      pos_in        = pos_ff;
      ch_in         = ch_ff;
      valid_in      = valid_ff;
      coef_in       = coef_ff;
      x_in          = x_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_load      = 1'b0;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            bqeq_pkg::CSR_ACTIVE:    active_in    = csr_wdata[0];
            bqeq_pkg::CSR_PRE_SCALE: pre_scale_in = csr_wdata;
            bqeq_pkg::CSR_CHANNELS:  channels_in  = csr_wdata[1:0];
            default: ;
         endcase
      end

      // result handoff
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      // history writes mark entries valid
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (uc.x_from_y) begin
         x_in = y_val;
      end
      if (uc.band_clr) begin
         band_in = '0;
      end

      // sequencing
      case (uc.seq)
         bqeq_pkg::SEQ_LOOP: begin
            if (band_last) begin
               upc_in = bqeq_pkg::upc_type'(upc_ff + 4'd1);
            end else begin
               band_in = band_ff + bqeq_pkg::BAND_W'(1);
               upc_in  = uc.target;
            end
         end
         bqeq_pkg::SEQ_WAIT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_tvalid_in = 1'b1;
               upc_in        = bqeq_pkg::UP_IDLE;
            end
         end
         default: begin
            if (upc_ff != bqeq_pkg::UP_IDLE) begin
               upc_in = bqeq_pkg::upc_type'(upc_ff + 4'd1);
            end
         end
      endcase

      // item dispatch
      if (accept) begin
         case (req_mode)
            bqeq_pkg::MODE_SAMPLE: begin
               x_in   = req_sample;
               ch_in  = bqeq_pkg::CH_W'(pos_cur);
               pos_in = bqeq_pkg::CH_W'(pos_nxt);
               upc_in = active_ff ? bqeq_pkg::UP_PRE_MUL : bqeq_pkg::UP_DONE;
            end
            bqeq_pkg::MODE_COEF: begin
               if (int'(req_coef_index) < bqeq_pkg::NCOEF) begin
                  coef_in[bqeq_pkg::CA_W'(req_coef_index)] = req_coef_value;
                  for (int c = 0; c < bqeq_pkg::MAX_CHANNELS; c++) begin
                     for (int b = 0; b < bqeq_pkg::BANDS; b++) begin
                        if ((int'(req_coef_index) >= b * 5) &&
                            (int'(req_coef_index) < b * 5 + 5)) begin
                           for (int k = 0; k < 4; k++) begin
                              valid_in[(c * bqeq_pkg::BANDS + b) * 4 + k] = 1'b0;
                           end
                        end
                     end
                  end
               end
            end
            bqeq_pkg::MODE_CLEAR: begin
               valid_in = '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tdata_in = rsp_load ? x_ff : rsp_tdata_ff;
   assign rsp_tuser_in = rsp_load ? ch_ff[0] : rsp_tuser_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pre_scale_ff  <= bqeq_pkg::Q_ONE;
         channels_ff   <= 2'd2;
         upc_ff        <= bqeq_pkg::UP_IDLE;
         band_ff       <= '0;
         pos_ff        <= '0;
         ch_ff         <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < bqeq_pkg::NCOEF; i++) begin
            coef_ff[i] <= 32'd0;
         end
      end else begin
         active_ff     <= active_in;
         pre_scale_ff  <= pre_scale_in;
         channels_ff   <= channels_in;
         upc_ff        <= upc_in;
         band_ff       <= band_in;
         pos_ff        <= pos_in;
         ch_ff         <= ch_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         coef_ff       <= coef_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // History RAM: one write, one registered read; valid flag travels with the data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: hdl/bqeq_checker.sv
// Port-level checks for the biquad cascade equalizer, attached to the top level by bind.
// Depends on bqeq_pkg for item kind codes.
module bqeq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a control item taken while no result is pending produces none
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid &&
      (req_tuser[1:0] != bqeq_pkg::MODE_SAMPLE) |=> !rsp_tvalid)
      else $error("result after a control item");

   // a sample transfer takes the block out of idle, so req_tready drops
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[1:0] == bqeq_pkg::MODE_SAMPLE) |=> !req_tready)
      else $error("req_tready high right after a sample transfer");

endmodule

bind biquad_cascade_equalizer_unit bqeq_checker u_bqeq_checker (.*);
